FILE: design/crl_pkg.sv
// Shared widths, constants and register codes for the colour ramp lookup.
package crl_pkg;

	// Table size is a power of two so the segment split is a shift and a mask.
	localparam int TABLE_BITS    = 10;
	localparam int TABLE_ENTRIES = 1 << TABLE_BITS;
	localparam int MAX_KEYS      = 7;
	localparam int PAIRS         = MAX_KEYS - 1;

	localparam int LEVEL_W   = 18;
	localparam int CLAMP_W   = 17;
	localparam int CHAN_W    = 8;
	localparam int COLOUR_W  = 32;
	localparam int COUNT_W   = 3;
	localparam int INDEX_W   = 4;
	localparam int PAIR_W    = $clog2(PAIRS);
	localparam int SCALE_W   = CLAMP_W + TABLE_BITS;
	localparam int PROD_W    = TABLE_BITS + COUNT_W;
	localparam int WEIGHT_W  = TABLE_BITS + 1;
	localparam int MIX_W     = CHAN_W + WEIGHT_W + 1;

	localparam logic [CLAMP_W-1:0]    ONE_Q16   = CLAMP_W'(65536);
	localparam logic [TABLE_BITS-1:0] ENTRY_MAX = TABLE_BITS'(TABLE_ENTRIES - 1);
	localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = WEIGHT_W'(TABLE_ENTRIES);
	localparam logic [MIX_W-1:0]      ROUND_HALF = MIX_W'(TABLE_ENTRIES / 2);
	localparam logic [COUNT_W-1:0]    KEYS_MIN  = COUNT_W'(2);
	localparam logic [COUNT_W-1:0]    KEYS_MAX  = COUNT_W'(MAX_KEYS);

	// Register indexes on the configuration port.
	localparam logic [INDEX_W-1:0] REG_KEY_COUNT    = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_KEY_COLOUR_0 = INDEX_W'(1);
	localparam logic [INDEX_W-1:0] REG_KEY_COLOUR_L = INDEX_W'(MAX_KEYS);

	// Two neighbouring key colours, held together so one index reads both.
	typedef struct packed {
		logic [COLOUR_W-1:0] lo_key;
		logic [COLOUR_W-1:0] hi_key;
	} pair_t;

endpackage

FILE: design/colour_ramp_lookup_top.sv
// Colour ramp lookup: level to RGBA through up to seven evenly spaced key colours.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  input   | in_valid / in_ready   | level (18b signed Q.16)
//  output  | out_valid / out_ready | out_red, out_green, out_blue, out_alpha
//  config  | cfg_valid / cfg_ready | cfg_index (4b), cfg_data (32b)
//
// Three register stages: clamp and scale to a table position, segment split
// and key pair select, channel blend. One beat per cycle while out_ready is high.
// The last stage is the output register; a stage holds while the one after it
// is full and stalled, so bubbles are squeezed out and nothing is dropped.
// Reset restores key_count 2 and a black to white ramp; cfg_ready is always high.
module colour_ramp_lookup_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [crl_pkg::LEVEL_W-1:0] level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [crl_pkg::CHAN_W-1:0]    out_red,
	output logic [crl_pkg::CHAN_W-1:0]    out_green,
	output logic [crl_pkg::CHAN_W-1:0]    out_blue,
	output logic [crl_pkg::CHAN_W-1:0]    out_alpha,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [crl_pkg::INDEX_W-1:0]   cfg_index,
	input  logic [crl_pkg::COLOUR_W-1:0]  cfg_data
);
	import crl_pkg::*;

	// Configuration
	logic [COUNT_W-1:0] key_count_q;
	pair_t              pair_q [PAIRS];
	logic               cfg_we;
	logic [INDEX_W-1:0] key_idx;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign key_idx   = cfg_index - REG_KEY_COLOUR_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KEYS_MIN;
			// Key one is the only white key after reset.
			for (int i = 0; i < PAIRS; i++) begin
				pair_q[i].lo_key <= (i == 1) ? {COLOUR_W{1'b1}} : {COLOUR_W{1'b0}};
				pair_q[i].hi_key <= (i == 0) ? {COLOUR_W{1'b1}} : {COLOUR_W{1'b0}};
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_COUNT) begin
				key_count_q <= cfg_data[COUNT_W-1:0];
			end else if (cfg_index >= REG_KEY_COLOUR_0 && cfg_index <= REG_KEY_COLOUR_L) begin
				// A key is the low end of one pair and the high end of the one below.
				for (int i = 0; i < PAIRS; i++) begin
					if (key_idx == INDEX_W'(i)) begin
						pair_q[i].lo_key <= cfg_data;
					end
					if (key_idx == INDEX_W'(i + 1)) begin
						pair_q[i].hi_key <= cfg_data;
					end
				end
			end
		end
	end

	// Stage flow control
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: clamp and scale to a table position
	logic [CLAMP_W-1:0]    clamped;
	logic [SCALE_W-1:0]    scaled;
	logic [COUNT_W-1:0]    keys;
	logic [TABLE_BITS-1:0] entry_s1;
	logic [COUNT_W-1:0]    ranges_s1;

	always_comb begin
		priority if (level[LEVEL_W-1]) begin
			clamped = '0;
		end else if (level[CLAMP_W-1:0] > ONE_Q16) begin
			clamped = ONE_Q16;
		end else begin
			clamped = level[CLAMP_W-1:0];
		end
		scaled = SCALE_W'(clamped) * SCALE_W'(ENTRY_MAX);

		priority if (key_count_q < KEYS_MIN) begin
			keys = KEYS_MIN;
		end else if (key_count_q > KEYS_MAX) begin
			keys = KEYS_MAX;
		end else begin
			keys = key_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			entry_s1  <= scaled[CLAMP_W-1 +: TABLE_BITS];
			ranges_s1 <= keys - COUNT_W'(1);
		end
	end

	// Stage 2: segment and fraction, pick the key pair
	logic [PROD_W-1:0]     prod;
	logic [COUNT_W-1:0]    seg;
	logic [COUNT_W-1:0]    seg_sel;
	pair_t                 pair_s2;
	logic [TABLE_BITS-1:0] rem_s2;

	always_comb begin
		prod = PROD_W'(entry_s1) * PROD_W'(ranges_s1);
		seg  = prod[PROD_W-1 -: COUNT_W];
		// Hold the segment inside the last range.
		if (seg >= ranges_s1) begin
			seg_sel = ranges_s1 - COUNT_W'(1);
		end else begin
			seg_sel = seg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pair_s2 <= pair_q[seg_sel[PAIR_W-1:0]];
			rem_s2  <= prod[TABLE_BITS-1:0];
		end
	end

	// Stage 3: blend each channel, round to nearest
	logic [CHAN_W-1:0]   blend [4];
	logic [WEIGHT_W-1:0] w_hi;
	logic [WEIGHT_W-1:0] w_lo;

	always_comb begin
		logic [MIX_W-1:0] mix;
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		w_hi = WEIGHT_W'(rem_s2);
		w_lo = WEIGHT_ONE - w_hi;
		mix  = '0;
		a    = '0;
		b    = '0;
		for (int ch = 0; ch < 4; ch++) begin
			a   = pair_s2.lo_key[COLOUR_W-1-CHAN_W*ch -: CHAN_W];
			b   = pair_s2.hi_key[COLOUR_W-1-CHAN_W*ch -: CHAN_W];
			mix = MIX_W'(a) * MIX_W'(w_lo) + MIX_W'(b) * MIX_W'(w_hi) + ROUND_HALF;
			if (mix[MIX_W-1:TABLE_BITS] > (MIX_W-TABLE_BITS)'({CHAN_W{1'b1}})) begin
				blend[ch] = '1;
			end else begin
				blend[ch] = mix[TABLE_BITS +: CHAN_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			out_red   <= blend[0];
			out_green <= blend[1];
			out_blue  <= blend[2];
			out_alpha <= blend[3];
		end
	end

	assign out_valid = valid_s3;

endmodule
